>>> hw/rtl/sc2c_pkg.sv
// Package for the scancode to character FIFO.
// Holds scancode constants, the AZERTY key table and the decode result type.
// No dependencies.
package sc2c_pkg;

    // Set-1 scancodes the block treats specially
    localparam logic [7:0] REL_BIT   = 8'h80;
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] SC_RETURN = 8'h1C;
    localparam logic [7:0] SC_SPACE  = 8'h39;
    localparam logic [7:0] SC_F1     = 8'h3B;
    localparam logic [7:0] SC_F2     = 8'h3C;

    // Characters pushed for return and space
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NONE    = 8'h00;

    // Console switch request codes
    localparam logic [1:0] SW_NONE  = 2'd0;
    localparam logic [1:0] SW_STD   = 2'd1;
    localparam logic [1:0] SW_DEBUG = 2'd2;

    // Decoded effect of one scancode
    typedef struct packed {
        logic       set_shift;
        logic       clr_shift;
        logic       tog_caps;
        logic       push;
        logic [7:0] ch;
        logic [1:0] sw;
    } t_dec;

    // AZERTY table: returns {upper, lower}, zero for codes with no entry
    function automatic logic [15:0] key_map(input logic [7:0] code);
        logic [15:0] r;
        r = 16'h0000;
        unique case (code)
            8'h02: r = {8'h31, 8'h26};
            8'h03: r = {8'h32, 8'd130};
            8'h04: r = {8'h33, 8'h22};
            8'h05: r = {8'h34, 8'h27};
            8'h06: r = {8'h35, 8'h28};
            8'h07: r = {8'h36, 8'h2D};
            8'h08: r = {8'h37, 8'd138};
            8'h09: r = {8'h38, 8'h5F};
            8'h0A: r = {8'h39, 8'd135};
            8'h0B: r = {8'h30, 8'd133};
            8'h0C: r = {8'd167, 8'h29};
            8'h0D: r = {8'h2B, 8'h3D};
            8'h10: r = {8'h41, 8'h61};
            8'h11: r = {8'h5A, 8'h7A};
            8'h12: r = {8'h45, 8'h65};
            8'h13: r = {8'h52, 8'h72};
            8'h14: r = {8'h54, 8'h74};
            8'h15: r = {8'h59, 8'h79};
            8'h16: r = {8'h55, 8'h75};
            8'h17: r = {8'h49, 8'h69};
            8'h18: r = {8'h4F, 8'h6F};
            8'h19: r = {8'h50, 8'h70};
            8'h1B: r = {8'd156, 8'h24};
            8'h1E: r = {8'h51, 8'h71};
            8'h1F: r = {8'h53, 8'h73};
            8'h20: r = {8'h44, 8'h64};
            8'h21: r = {8'h46, 8'h66};
            8'h22: r = {8'h47, 8'h67};
            8'h23: r = {8'h48, 8'h68};
            8'h24: r = {8'h4A, 8'h6A};
            8'h25: r = {8'h4B, 8'h6B};
            8'h26: r = {8'h4C, 8'h6C};
            8'h27: r = {8'h4D, 8'h6D};
            8'h28: r = {8'h25, 8'd151};
            8'h2B: r = {8'd230, 8'h2A};
            8'h2C: r = {8'h57, 8'h77};
            8'h2D: r = {8'h58, 8'h78};
            8'h2E: r = {8'h43, 8'h63};
            8'h2F: r = {8'h56, 8'h76};
            8'h30: r = {8'h42, 8'h62};
            8'h31: r = {8'h4E, 8'h6E};
            8'h32: r = {8'h3F, 8'h2C};
            8'h33: r = {8'h2E, 8'h3B};
            8'h34: r = {8'h2F, 8'h3A};
            8'h35: r = {8'hA7, 8'h21};
            8'h56: r = {8'h3E, 8'h3C};
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/sc2c_in_if.sv
// Input channel interface: valid/ready handshake with action and scancode.
// Depends on nothing.
interface sc2c_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] scan_byte;

    modport source (output valid, output action, output scan_byte, input ready);
    modport sink   (input valid, input action, input scan_byte, output ready);
endinterface

>>> hw/rtl/sc2c_out_if.sv
// Result channel interface: valid/ready handshake with the result fields.
// Depends on nothing.
interface sc2c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] popped_char;
    logic       pop_empty;
    logic       push_dropped;
    logic [1:0] switch_request;

    modport source (output valid, output popped_char, output pop_empty,
                    output push_dropped, output switch_request, input ready);
    modport sink   (input valid, input popped_char, input pop_empty,
                    input push_dropped, input switch_request, output ready);
endinterface

>>> hw/rtl/sc2c_decode.sv
// Scancode decoder: turns one set-1 byte plus shift/caps state into an effect.
// Depends on sc2c_pkg.
module sc2c_decode (
    input  logic [7:0]    i_scan_byte,
    input  logic          i_shift,
    input  logic          i_caps,
    output sc2c_pkg::t_dec o_dec
);
    import sc2c_pkg::*;

    logic [15:0] map_word;

    assign map_word = key_map(i_scan_byte);

    // Special codes first, table lookup for the rest
    always_comb begin
        o_dec = '0;
        o_dec.ch = CH_NONE;
        o_dec.sw = SW_NONE;
        priority if (i_scan_byte == SC_LSHIFT || i_scan_byte == SC_RSHIFT) begin
            o_dec.set_shift = 1'b1;
        end else if (i_scan_byte == (SC_LSHIFT | REL_BIT) ||
                     i_scan_byte == (SC_RSHIFT | REL_BIT)) begin
            o_dec.clr_shift = 1'b1;
        end else if (i_scan_byte == SC_CAPS) begin
            o_dec.tog_caps = 1'b1;
        end else if (i_scan_byte == SC_RETURN) begin
            o_dec.push = 1'b1;
            o_dec.ch   = CH_NEWLINE;
        end else if (i_scan_byte == SC_SPACE) begin
            o_dec.push = 1'b1;
            o_dec.ch   = CH_SPACE;
        end else if (i_scan_byte == SC_F1) begin
            o_dec.sw = SW_STD;
        end else if (i_scan_byte == SC_F2) begin
            o_dec.sw = SW_DEBUG;
        end else begin
            // upper character when shift XOR caps
            o_dec.ch   = (i_shift ^ i_caps) ? map_word[15:8] : map_word[7:0];
            o_dec.push = (o_dec.ch != CH_NONE);
        end
    end

endmodule

>>> hw/rtl/scancode_to_char_fifo.sv
// Top level: set-1 scancode to AZERTY character FIFO with pop requests.
// Depends on sc2c_pkg, sc2c_in_if, sc2c_out_if and sc2c_decode.
//
//  channel  | dir | fields                                              
//  ---------+-----+----------------------------------------------------
//  i_in     | in  | action, scan_byte                                   
//  o_out    | out | popped_char, pop_empty, push_dropped, switch_request
//
// One word in, one result word out, one word per cycle sustained while the receiver takes each result.
// The result is valid in the cycle after the accept: decode, pointer update and store access happen at
// the accept edge; the store read data lands in the result register.
// i_rst_n (synchronous, active low) clears pointers, shift, caps and the
// result valid; the character store is not cleared.
// While a result waits, a new word is taken only as the result is taken.
module scancode_to_char_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sc2c_in_if.sink       i_in,
    sc2c_out_if.source    o_out
);
    import sc2c_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    // Character store
    logic [7:0] r_store [FIFO_DEPTH];

    // Control state
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic             r_shift, n_shift;
    logic             r_caps, n_caps;
    logic             r_out_valid, n_out_valid;

    // Result payload
    logic [7:0] r_pop_char;
    logic       r_pop_ok, n_pop_ok;
    logic       r_pop_empty, n_pop_empty;
    logic       r_dropped, n_dropped;
    logic [1:0] r_sw, n_sw;

    logic             accept;
    logic             fifo_empty;
    logic             fifo_full;
    logic             do_push;
    logic             do_pop;
    logic [PTR_W-1:0] rd_inc;
    logic [PTR_W-1:0] wr_inc;
    t_dec             dec;

    sc2c_decode u_decode (
        .i_scan_byte (i_in.scan_byte),
        .i_shift     (r_shift),
        .i_caps      (r_caps),
        .o_dec       (dec)
    );

    // Handshake: the result register frees as it is taken
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Ring pointers and fill tests
    assign rd_inc     = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
    assign wr_inc     = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
    assign fifo_empty = (r_rd_ptr == r_wr_ptr);
    assign fifo_full  = (wr_inc == r_rd_ptr);
    assign do_pop     = accept && i_in.action && !fifo_empty;
    assign do_push    = accept && !i_in.action && dec.push && !fifo_full;

    // Next state and result
    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_shift     = r_shift;
        n_caps      = r_caps;
        n_out_valid = r_out_valid && !o_out.ready;
        n_pop_ok    = r_pop_ok;
        n_pop_empty = r_pop_empty;
        n_dropped   = r_dropped;
        n_sw        = r_sw;
        if (accept) begin
            n_out_valid = 1'b1;
            n_pop_ok    = do_pop;
            n_pop_empty = i_in.action && fifo_empty;
            n_dropped   = !i_in.action && dec.push && fifo_full;
            n_sw        = i_in.action ? SW_NONE : dec.sw;
            if (do_pop) begin
                n_rd_ptr = rd_inc;
            end
            if (do_push) begin
                n_wr_ptr = wr_inc;
            end
            if (!i_in.action) begin
                if (dec.set_shift) begin
                    n_shift = 1'b1;
                end
                if (dec.clr_shift) begin
                    n_shift = 1'b0;
                end
                if (dec.tog_caps) begin
                    n_caps = !r_caps;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_shift     <= n_shift;
            r_caps      <= n_caps;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pop_ok    <= n_pop_ok;
        r_pop_empty <= n_pop_empty;
        r_dropped   <= n_dropped;
        r_sw        <= n_sw;
    end

    // Store write port
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= dec.ch;
        end
    end

    // Store read port, registered
    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_pop_char <= r_store[r_rd_ptr];
        end
    end

    // Result word
    assign o_out.valid          = r_out_valid;
    assign o_out.popped_char    = r_pop_ok ? r_pop_char : CH_NONE;
    assign o_out.pop_empty      = r_pop_empty;
    assign o_out.push_dropped   = r_dropped;
    assign o_out.switch_request = r_sw;

endmodule

>>> hw/rtl/sc2c_check.sv
// Port-level checker for scancode_to_char_fifo, with its bind statement.
// Depends on scancode_to_char_fifo and sc2c_pkg.
module sc2c_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_popped_char,
    input logic       i_pop_empty,
    input logic       i_push_dropped,
    input logic [1:0] i_switch_request
);
    import sc2c_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid &&
            $stable(i_popped_char) && $stable(i_pop_empty) &&
            $stable(i_push_dropped) && $stable(i_switch_request)))
        else $error("result word changed while stalled");

    // Every accepted word gives a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted word gave no result");

    // An empty pop carries no character, drop or switch request
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_pop_empty) |-> (i_popped_char == CH_NONE &&
            !i_push_dropped && i_switch_request == SW_NONE))
        else $error("empty pop with other fields set");

    // A dropped push is a scancode word: no popped character, no switch
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_push_dropped) |-> (i_popped_char == CH_NONE &&
            i_switch_request == SW_NONE))
        else $error("dropped push with other fields set");

    // Reset empties the result register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind scancode_to_char_fifo sc2c_check u_sc2c_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_popped_char    (o_out.popped_char),
    .i_pop_empty      (o_out.pop_empty),
    .i_push_dropped   (o_out.push_dropped),
    .i_switch_request (o_out.switch_request)
);

>>> verif/scancode_to_char_fifo_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for scancode_to_char_fifo (AZERTY keyboard to character FIFO).
// Depends on sc2c_pkg, sc2c_in_if, sc2c_out_if and the RTL top level.
module scancode_to_char_fifo_tb;
    import sc2c_pkg::*;

    localparam int FIFO_DEPTH = 256;
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_POP  = 1'b1;
    localparam int MAX_PRINTED = 30;

    // One result word as the block should return it
    typedef struct packed {
        logic [7:0] ch;
        logic       empty;
        logic       dropped;
        logic [1:0] sw;
    } t_char_result;

    logic i_clk;
    logic i_rst_n;

    sc2c_in_if  in_if ();
    sc2c_out_if out_if ();

    scancode_to_char_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted keyboard state and the characters it has queued
    logic         shift_down;
    logic         caps_latched;
    logic [7:0]   typed_chars[$];
    t_char_result results_due[$];

    int src_gap_pct;
    int sink_stall_pct;
    int error_count;
    int words_sent;
    int results_checked;
    int drops_seen;
    int empties_seen;
    int switches_seen;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still due", results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver back-pressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic flag_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // AZERTY lookup, {lower, upper}; zero where the key has no character
    function automatic logic [7:0] azerty_char(input logic [7:0] code, input logic upper);
        logic [15:0] pair;
        pair = 16'h0000;
        case (code)
            8'h02: pair = {"&", "1"};      8'h03: pair = {8'd130, "2"};
            8'h04: pair = {"\"", "3"};     8'h05: pair = {"'", "4"};
            8'h06: pair = {"(", "5"};      8'h07: pair = {"-", "6"};
            8'h08: pair = {8'd138, "7"};   8'h09: pair = {"_", "8"};
            8'h0A: pair = {8'd135, "9"};   8'h0B: pair = {8'd133, "0"};
            8'h0C: pair = {")", 8'd167};   8'h0D: pair = {"=", "+"};
            8'h10: pair = {"a", "A"};      8'h11: pair = {"z", "Z"};
            8'h12: pair = {"e", "E"};      8'h13: pair = {"r", "R"};
            8'h14: pair = {"t", "T"};      8'h15: pair = {"y", "Y"};
            8'h16: pair = {"u", "U"};      8'h17: pair = {"i", "I"};
            8'h18: pair = {"o", "O"};      8'h19: pair = {"p", "P"};
            8'h1B: pair = {"$", 8'd156};   8'h1E: pair = {"q", "Q"};
            8'h1F: pair = {"s", "S"};      8'h20: pair = {"d", "D"};
            8'h21: pair = {"f", "F"};      8'h22: pair = {"g", "G"};
            8'h23: pair = {"h", "H"};      8'h24: pair = {"j", "J"};
            8'h25: pair = {"k", "K"};      8'h26: pair = {"l", "L"};
            8'h27: pair = {"m", "M"};      8'h28: pair = {8'd151, "%"};
            8'h2B: pair = {"*", 8'd230};   8'h2C: pair = {"w", "W"};
            8'h2D: pair = {"x", "X"};      8'h2E: pair = {"c", "C"};
            8'h2F: pair = {"v", "V"};      8'h30: pair = {"b", "B"};
            8'h31: pair = {"n", "N"};      8'h32: pair = {",", "?"};
            8'h33: pair = {";", "."};      8'h34: pair = {":", "/"};
            8'h35: pair = {"!", 8'hA7};    8'h56: pair = {"<", ">"};
            default: pair = 16'h0000;
        endcase
        return upper ? pair[7:0] : pair[15:8];
    endfunction

    // Works out the result of one accepted word and updates the predicted state
    task automatic predict_char_step(input logic act, input logic [7:0] code);
        t_char_result r;
        logic [7:0]   ch;
        r  = '0;
        ch = CH_NONE;
        if (act == ACT_POP) begin
            if (typed_chars.size() == 0)
                r.empty = 1'b1;
            else
                r.ch = typed_chars.pop_front();
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_down = 1'b1;
        end else if (code == (SC_LSHIFT | REL_BIT) || code == (SC_RSHIFT | REL_BIT)) begin
            shift_down = 1'b0;
        end else if (code == SC_CAPS) begin
            caps_latched = ~caps_latched;
        end else if (code == SC_RETURN) begin
            ch = CH_NEWLINE;
        end else if (code == SC_SPACE) begin
            ch = CH_SPACE;
        end else if (code == SC_F1) begin
            r.sw = SW_STD;
        end else if (code == SC_F2) begin
            r.sw = SW_DEBUG;
        end else begin
            ch = azerty_char(code, shift_down ^ caps_latched);
        end
        // Ring buffer keeps one slot free
        if (act == ACT_SCAN && ch != CH_NONE) begin
            if (typed_chars.size() == FIFO_DEPTH - 1)
                r.dropped = 1'b1;
            else
                typed_chars.push_back(ch);
        end
        results_due.push_back(r);
    endtask

    // Sends one word, with an optional idle gap first; valid stays high afterwards
    task automatic send_word(input logic act, input logic [7:0] code);
        if ($urandom_range(99) < src_gap_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_gap_pct);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= act;
        in_if.scan_byte <= code;
        do @(posedge i_clk); while (!in_if.ready);
        predict_char_step(act, code);
        words_sent++;
    endtask

    // Hold the sender off until every result has come back
    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    function automatic logic [7:0] pick_key_code();
        logic [7:0] code;
        do code = 8'($urandom_range(8'h56, 8'h02)); while (azerty_char(code, 1'b0) == CH_NONE);
        return code;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_char_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("result word with nothing due: char %02h",
                                        out_if.popped_char));
            end else begin
                want = results_due.pop_front();
                if (out_if.popped_char !== want.ch)
                    flag_mismatch($sformatf("popped_char %02h, want %02h",
                                            out_if.popped_char, want.ch));
                if (out_if.pop_empty !== want.empty)
                    flag_mismatch($sformatf("pop_empty %b, want %b", out_if.pop_empty, want.empty));
                if (out_if.push_dropped !== want.dropped)
                    flag_mismatch($sformatf("push_dropped %b, want %b",
                                            out_if.push_dropped, want.dropped));
                if (out_if.switch_request !== want.sw)
                    flag_mismatch($sformatf("switch_request %0d, want %0d",
                                            out_if.switch_request, want.sw));
            end
            results_checked++;
            if (out_if.push_dropped === 1'b1) drops_seen++;
            if (out_if.pop_empty === 1'b1) empties_seen++;
            if (out_if.switch_request !== SW_NONE) switches_seen++;
        end
    end

    // Every special key, both shifts, caps with and without shift, section sign
    task automatic test_directed_keys();
        send_word(ACT_POP, 8'hFF);         // pop on empty
        send_word(ACT_SCAN, 8'h00);        // unmapped
        send_word(ACT_SCAN, 8'hFF);        // release of nothing
        send_word(ACT_SCAN, 8'h10);
        send_word(ACT_SCAN, SC_LSHIFT);
        send_word(ACT_SCAN, 8'h10);
        send_word(ACT_SCAN, 8'h35);        // section sign
        send_word(ACT_SCAN, SC_LSHIFT | REL_BIT);
        send_word(ACT_SCAN, SC_RSHIFT);
        send_word(ACT_SCAN, 8'h56);
        send_word(ACT_SCAN, SC_RSHIFT | REL_BIT);
        send_word(ACT_SCAN, SC_CAPS);
        send_word(ACT_SCAN, 8'h02);
        send_word(ACT_SCAN, SC_LSHIFT);    // shift with caps gives lower case
        send_word(ACT_SCAN, 8'h56);
        send_word(ACT_SCAN, SC_LSHIFT | REL_BIT);
        send_word(ACT_SCAN, SC_CAPS);
        send_word(ACT_SCAN, SC_RETURN);
        send_word(ACT_SCAN, SC_SPACE);
        send_word(ACT_SCAN, SC_F1);
        send_word(ACT_SCAN, SC_F2);
        send_word(ACT_SCAN, 8'h90);        // key release, no effect
        send_word(ACT_POP, 8'h00);
        send_word(ACT_POP, 8'h5A);
        send_word(ACT_POP, 8'hA5);
    endtask

    // Fill the FIFO, push into it while full, then read it dry
    task automatic test_fifo_full();
        int extra;
        extra = 0;
        while (typed_chars.size() < FIFO_DEPTH - 1 || extra < 6) begin
            if (typed_chars.size() == FIFO_DEPTH - 1) extra++;
            case ($urandom_range(9))
                0: send_word(ACT_SCAN, shift_down ? SC_RSHIFT | REL_BIT : SC_RSHIFT);
                1: send_word(ACT_SCAN, SC_RETURN);
                2: send_word(ACT_SCAN, SC_SPACE);
                default: send_word(ACT_SCAN, pick_key_code());
            endcase
        end
        while (typed_chars.size() != 0)
            send_word(ACT_POP, 8'($urandom));
        send_word(ACT_POP, 8'($urandom));
    endtask

    // Typing with random keys, shifted runs, caps, return/space, F1/F2, key releases, pops and raw noise
    task automatic test_random_typing(input int n_words);
        int   start;
        int   r;
        logic drained;
        start   = words_sent;
        drained = 1'b0;
        while (words_sent - start < n_words) begin
            // one full drain about halfway through
            if (!drained && words_sent - start >= n_words / 2) begin
                wait_results_drained();
                drained = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 40) begin
                send_word(ACT_POP, 8'($urandom));
            end else if (r < 72) begin
                send_word(ACT_SCAN, pick_key_code());
            end else if (r < 82) begin
                r = $urandom_range(1);
                send_word(ACT_SCAN, r ? SC_LSHIFT : SC_RSHIFT);
                repeat ($urandom_range(3, 1)) send_word(ACT_SCAN, pick_key_code());
                send_word(ACT_SCAN, (r ? SC_LSHIFT : SC_RSHIFT) | REL_BIT);
            end else if (r < 85) begin
                send_word(ACT_SCAN, SC_CAPS);
            end else if (r < 89) begin
                send_word(ACT_SCAN, $urandom_range(1) ? SC_RETURN : SC_SPACE);
            end else if (r < 91) begin
                send_word(ACT_SCAN, $urandom_range(1) ? SC_F1 : SC_F2);
            end else if (r < 94) begin
                send_word(ACT_SCAN, pick_key_code() | REL_BIT);
            end else begin
                send_word(ACT_SCAN, 8'($urandom));
            end
        end
    endtask

    initial begin
        int gap_pct[4];
        int stall_pct[4];
        int wait_cycles;
        gap_pct   = '{0, 51, 0, 29};
        stall_pct = '{0, 0, 51, 29};
        shift_down      = 1'b0;
        caps_latched    = 1'b0;
        src_gap_pct     = 0;
        sink_stall_pct  = 0;
        error_count     = 0;
        words_sent      = 0;
        results_checked = 0;
        drops_seen      = 0;
        empties_seen    = 0;
        switches_seen   = 0;
        in_if.valid     <= 1'b0;
        in_if.action    <= ACT_SCAN;
        in_if.scan_byte <= 8'h00;
        i_rst_n         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_keys();
        test_fifo_full();
        for (int p = 0; p < 4; p++) begin
            src_gap_pct    = gap_pct[p];
            sink_stall_pct = stall_pct[p];
            test_random_typing(230);
        end

        // Drain and let the pipeline settle
        in_if.valid <= 1'b0;
        sink_stall_pct = 0;
        wait_cycles = 0;
        while (results_due.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("Sent %0d words, checked %0d results under four idle/stall mixes",
                 words_sent, results_checked);
        $display("Seen %0d dropped pushes, %0d empty pops, %0d console switches",
                 drops_seen, empties_seen, switches_seen);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
